[rtl/core/ustc_pkg.sv]
// Shared types and constants for the UTF-8/16/32 stream transcoder.
// Used by ustc_front, ustc_queue, ustc_back and the top level.
package ustc_pkg;

	// direction register codes
	typedef enum logic [2:0] {
		MODE_U8TO32  = 3'd0,
		MODE_U32TO8  = 3'd1,
		MODE_U16TO32 = 3'd2,
		MODE_U32TO16 = 3'd3,
		MODE_U8TO16  = 3'd4,
		MODE_U16TO8  = 3'd5
	} mode_t;

	// target encoding of a queued character
	typedef enum logic [1:0] {
		FORM_U8  = 2'd0,
		FORM_U16 = 2'd1,
		FORM_U32 = 2'd2
	} form_t;

	localparam int unsigned SRC_W      = 32;
	localparam int unsigned CP_W       = 21;
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned CFG_W      = 8;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [CP_W-1:0]  CP_2BYTE   = 21'h00080;
	localparam logic [CP_W-1:0]  CP_3BYTE   = 21'h00800;
	localparam logic [CP_W-1:0]  CP_SUPP    = 21'h10000;
	localparam logic [CP_W-1:0]  CP_LIMIT   = 21'h110000;
	localparam logic [SRC_W-1:0] SRC_LIMIT  = 32'h0011_0000;

	// one decoded character waiting to be encoded
	typedef struct packed {
		logic [CP_W-1:0] cp;
		form_t           form;
		logic [1:0]      last_idx; // number of target units minus one
	} job_t;

endpackage

[rtl/core/ustc_front.sv]
// Front end: takes source units, holds the direction register and the
// partial character, and pushes complete characters as jobs. Uses ustc_pkg.
module ustc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [ustc_pkg::CFG_W-1:0] cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ustc_pkg::SRC_W-1:0] s_tdata,
	input  logic                      queue_full,
	output logic                      push_valid,
	output ustc_pkg::job_t            push_job
);
	import ustc_pkg::*;

	mode_t           mode_q;
	logic [CP_W-1:0] pp_q;
	logic [1:0]      pend_q;

	logic            accept;
	logic [7:0]      byte_in;
	logic [15:0]     half_in;
	logic            done;
	logic [CP_W-1:0] cp;
	logic [CP_W-1:0] pp_nxt;
	logic [1:0]      pend_nxt;
	logic            fits;
	logic [1:0]      last_idx;
	form_t           form;

	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;
	assign byte_in  = s_tdata[7:0];
	assign half_in  = s_tdata[15:0];

	// decode
	always_comb begin
		done     = 1'b0;
		cp       = '0;
		pp_nxt   = pp_q;
		pend_nxt = pend_q;
		unique case (mode_q)
			MODE_U8TO32, MODE_U8TO16: begin
				if (pend_q != 2'd0) begin
					pp_nxt   = {pp_q[14:0], byte_in[5:0]};
					pend_nxt = pend_q - 2'd1;
					done     = (pend_q == 2'd1);
					cp       = {pp_q[14:0], byte_in[5:0]};
				end else if (!byte_in[7]) begin
					done = 1'b1;
					cp   = {13'd0, byte_in};
				end else if (byte_in[7:5] == 3'b110) begin
					pp_nxt   = {16'd0, byte_in[4:0]};
					pend_nxt = 2'd1;
				end else if (byte_in[7:4] == 4'b1110) begin
					pp_nxt   = {17'd0, byte_in[3:0]};
					pend_nxt = 2'd2;
				end else if (byte_in[7:3] == 5'b11110) begin
					pp_nxt   = {18'd0, byte_in[2:0]};
					pend_nxt = 2'd3;
				end
			end
			MODE_U16TO32, MODE_U16TO8: begin
				if (pend_q != 2'd0) begin
					pend_nxt = 2'd0;
					done     = 1'b1;
					cp       = {1'b0, pp_q[9:0], half_in[9:0]} + CP_SUPP;
				end else if (half_in[15:11] != 5'b11011) begin
					done = 1'b1;
					cp   = {5'd0, half_in};
				end else if (!half_in[10]) begin
					// lead surrogate; a lone trail is dropped
					pp_nxt   = {11'd0, half_in[9:0]};
					pend_nxt = 2'd1;
				end
			end
			MODE_U32TO8, MODE_U32TO16: begin
				done = (s_tdata < SRC_LIMIT);
				cp   = s_tdata[CP_W-1:0];
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	// classify target length
	always_comb begin
		fits     = 1'b1;
		last_idx = 2'd0;
		form     = FORM_U32;
		unique case (mode_q)
			MODE_U32TO8, MODE_U16TO8: begin
				form = FORM_U8;
				if (cp < CP_2BYTE)      last_idx = 2'd0;
				else if (cp < CP_3BYTE) last_idx = 2'd1;
				else if (cp < CP_SUPP)  last_idx = 2'd2;
				else if (cp < CP_LIMIT) last_idx = 2'd3;
				else                    fits     = 1'b0;
			end
			MODE_U32TO16, MODE_U8TO16: begin
				form = FORM_U16;
				if (cp < CP_SUPP)       last_idx = 2'd0;
				else if (cp < CP_LIMIT) last_idx = 2'd1;
				else                    fits     = 1'b0;
			end
			default: begin
				form = FORM_U32;
			end
		endcase
	end

	assign push_valid        = accept && done && fits;
	assign push_job.cp       = cp;
	assign push_job.form     = form;
	assign push_job.last_idx = last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_U8TO32;
			pp_q   <= '0;
			pend_q <= 2'd0;
		end else if (cfg_valid) begin
			// a mode change drops any character in progress
			mode_q <= mode_t'(cfg_data[2:0]);
			pp_q   <= '0;
			pend_q <= 2'd0;
		end else if (accept) begin
			pp_q   <= pp_nxt;
			pend_q <= pend_nxt;
		end
	end

endmodule

[rtl/core/ustc_queue.sv]
// Short job FIFO between front and back end; push and pop can coincide.
// Uses ustc_pkg for the job type.
module ustc_queue #(
	parameter int unsigned DEPTH = ustc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ustc_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output ustc_pkg::job_t head_job
);
	import ustc_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[rtl/core/ustc_back.sv]
// Back end: holds the current job and emits its target units one per cycle while m_tready is high.
// Uses ustc_pkg for the job type and encoding constants.
module ustc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             empty,
	input  ustc_pkg::job_t                   head_job,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ustc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tlast
);
	import ustc_pkg::*;

	job_t            cur_q;
	logic            valid_q;
	logic [1:0]      idx_q;
	logic            take_out;
	logic [CP_W-1:0] unit;
	logic [1:0]      group;
	logic [5:0]      cont;
	logic [19:0]     ofs;

	assign m_tvalid = valid_q;
	assign m_tlast  = (idx_q == cur_q.last_idx);
	assign take_out = valid_q && m_tready;
	assign pop      = !empty && (!valid_q || (take_out && m_tlast));
	assign m_tdata  = {(OUT_TDATA_W - CP_W)'(0), unit};

	// continuation byte payload, counted from the end
	assign group = cur_q.last_idx - idx_q;
	always_comb begin
		unique case (group)
			2'd0:    cont = cur_q.cp[5:0];
			2'd1:    cont = cur_q.cp[11:6];
			2'd2:    cont = cur_q.cp[17:12];
			default: cont = 6'd0;
		endcase
	end

	assign ofs = 20'(cur_q.cp - CP_SUPP);

	always_comb begin
		unit = cur_q.cp;
		unique case (cur_q.form)
			FORM_U8: begin
				if (idx_q != 2'd0) begin
					unit = {13'd0, 2'b10, cont};
				end else begin
					unique case (cur_q.last_idx)
						2'd0: unit = cur_q.cp;
						2'd1: unit = {13'd0, 3'b110, cur_q.cp[10:6]};
						2'd2: unit = {13'd0, 4'b1110, cur_q.cp[15:12]};
						2'd3: unit = {13'd0, 5'b11110, cur_q.cp[20:18]};
					endcase
				end
			end
			FORM_U16: begin
				if (cur_q.last_idx == 2'd0) begin
					unit = cur_q.cp;
				end else if (idx_q == 2'd0) begin
					unit = {5'd0, 6'b110110, ofs[19:10]};
				end else begin
					unit = {5'd0, 6'b110111, ofs[9:0]};
				end
			end
			default: begin
				unit = cur_q.cp;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (take_out) begin
			if (m_tlast) begin
				valid_q <= 1'b0;
				idx_q   <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

[rtl/core/unicode_stream_transcoder_unit.sv]
// Top level of the UTF-8 / UTF-16 / UTF-32 stream transcoder.
// Depends on ustc_pkg, ustc_front, ustc_queue and ustc_back.
//
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+----------------------------------------
// cfg      | in  | cfg_valid/cfg_ready| cfg_data[2:0] direction_mode
// s (src)  | in  | s_tvalid/s_tready  | s_tdata[31:0] source_unit
// m (dst)  | out | m_tvalid/m_tready  | m_tdata[20:0] target_unit, m_tlast last_unit
//
// One source unit is taken per cycle while the job queue has room; decode and
// classification finish in the cycle of the transaction. Each character yields
// 1 to 4 target units, one per cycle from the back end while m_tready is high.
// The job queue (QUEUE_DEPTH entries) lets the source keep flowing while the
// back end works off a burst or waits on m_tready; s_tready drops only when the
// queue is full. arst_n clears mode (8-to-32), partial character, queue and
// output; a cfg transaction is always taken and abandons any partial character.
module unicode_stream_transcoder_unit #(
	parameter int unsigned QUEUE_DEPTH = ustc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ustc_pkg::CFG_W-1:0]       cfg_data,   // [2:0] direction_mode
	// source units
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ustc_pkg::SRC_W-1:0]       s_tdata,    // [31:0] source_unit
	// target units
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ustc_pkg::OUT_TDATA_W-1:0] m_tdata,    // [20:0] target_unit, rest zero
	output logic                             m_tlast     // last_unit
);
	import ustc_pkg::*;

	logic push_valid;
	job_t push_job;
	logic queue_full;
	logic queue_empty;
	logic queue_pop;
	job_t head_job;

	// register writes never stall
	assign cfg_ready = 1'b1;

	ustc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	ustc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (queue_pop),
		.empty    (queue_empty),
		.head_job (head_job)
	);

	ustc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (queue_empty),
		.head_job (head_job),
		.pop      (queue_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[test/ustc_stream_checker.sv]
// Scoreboard for the UTF-8/16/32 stream transcoder: watches cfg, s and m channels,
// predicts target units per source transaction and compares them in order.
// Depends on ustc_pkg for widths and direction codes.
module ustc_stream_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [ustc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [ustc_pkg::SRC_W-1:0]       s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [ustc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             m_tlast,
	input  logic                             run_done,
	output int                               errors,
	output int                               pending,
	output int                               units_checked
);
	import ustc_pkg::*;

	typedef struct packed {
		logic [CP_W-1:0] code;
		logic            is_last;
	} target_unit_t;

	// mode kept as raw bits: the spare codes 6 and 7 are legal writes
	logic [2:0]      dir_mode;
	logic [CP_W-1:0] partial_cp;
	logic [1:0]      units_left;
	target_unit_t    expected_units[$];

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t ustc_stream_checker: %s", $time, what);
	endtask

	task automatic put_unit(input logic [31:0] u, input logic last_flag);
		target_unit_t t;
		t.code = u[CP_W-1:0];
		t.is_last = last_flag;
		expected_units.push_back(t);
	endtask

	task automatic encode_utf8(input logic [31:0] cp);
		if (cp < 32'h80) begin
			put_unit(cp, 1'b1);
		end else if (cp < 32'h800) begin
			put_unit((cp >> 6) | 32'hC0, 1'b0);
			put_unit((cp & 32'h3F) | 32'h80, 1'b1);
		end else if (cp < 32'h10000) begin
			put_unit((cp >> 12) | 32'hE0, 1'b0);
			put_unit(((cp >> 6) & 32'h3F) | 32'h80, 1'b0);
			put_unit((cp & 32'h3F) | 32'h80, 1'b1);
		end else if (cp < SRC_LIMIT) begin
			put_unit((cp >> 18) | 32'hF0, 1'b0);
			put_unit(((cp >> 12) & 32'h3F) | 32'h80, 1'b0);
			put_unit(((cp >> 6) & 32'h3F) | 32'h80, 1'b0);
			put_unit((cp & 32'h3F) | 32'h80, 1'b1);
		end
	endtask

	task automatic encode_utf16(input logic [31:0] cp);
		logic [31:0] offs;
		if (cp < 32'h10000) begin
			put_unit(cp, 1'b1);
		end else if (cp < SRC_LIMIT) begin
			offs = cp - 32'h10000;
			put_unit((offs >> 10) + 32'hD800, 1'b0);
			put_unit((offs & 32'h3FF) + 32'hDC00, 1'b1);
		end
	endtask

	// continuation bytes are taken on trust: only their low 6 bits count
	task automatic decode_utf8(input logic [7:0] b, output bit done, output logic [31:0] cp);
		done = 1'b0;
		cp = '0;
		if (units_left != 2'd0) begin
			partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
			units_left = units_left - 2'd1;
			if (units_left == 2'd0) begin
				done = 1'b1;
				cp = {11'b0, partial_cp};
			end
		end else if (!b[7]) begin
			done = 1'b1;
			cp = {24'b0, b};
		end else if (b[7:5] == 3'b110) begin
			partial_cp = {16'b0, b[4:0]};
			units_left = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			partial_cp = {17'b0, b[3:0]};
			units_left = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			partial_cp = {18'b0, b[2:0]};
			units_left = 2'd3;
		end
	endtask

	// any unit after a lead surrogate completes the pair, low 10 bits only
	task automatic decode_utf16(input logic [15:0] u, output bit done, output logic [31:0] cp);
		done = 1'b0;
		cp = '0;
		if (units_left != 2'd0) begin
			units_left = 2'd0;
			done = 1'b1;
			cp = {12'b0, partial_cp[9:0], u[9:0]} + 32'h10000;
		end else if (u < 16'hD800 || u > 16'hDFFF) begin
			done = 1'b1;
			cp = {16'b0, u};
		end else if (u < 16'hDC00) begin
			partial_cp = {11'b0, u[9:0]};
			units_left = 2'd1;
		end
	endtask

	task automatic predict_source(input logic [SRC_W-1:0] src);
		bit          done;
		logic [31:0] cp;
		case (dir_mode)
			MODE_U8TO32: begin
				decode_utf8(src[7:0], done, cp);
				if (done) put_unit(cp, 1'b1);
			end
			MODE_U32TO8:  encode_utf8(src);
			MODE_U16TO32: begin
				decode_utf16(src[15:0], done, cp);
				if (done) put_unit(cp, 1'b1);
			end
			MODE_U32TO16: encode_utf16(src);
			MODE_U8TO16: begin
				decode_utf8(src[7:0], done, cp);
				if (done) encode_utf16(cp);
			end
			MODE_U16TO8: begin
				decode_utf16(src[15:0], done, cp);
				if (done) encode_utf8(cp);
			end
			default: ;
		endcase
	endtask

	task automatic check_target(input logic [OUT_TDATA_W-1:0] data, input logic last_flag);
		target_unit_t want;
		units_checked++;
		if (data[OUT_TDATA_W-1:CP_W] !== '0) begin
			report_mismatch($sformatf("tdata pad bits not zero: %h", data));
		end
		if (expected_units.size() == 0) begin
			report_mismatch($sformatf("unexpected target unit %h last %b", data, last_flag));
		end else begin
			want = expected_units.pop_front();
			if (data[CP_W-1:0] !== want.code) begin
				report_mismatch($sformatf("target_unit %h, expected %h",
					data[CP_W-1:0], want.code));
			end
			if (last_flag !== want.is_last) begin
				report_mismatch($sformatf("last_unit %b, expected %b on unit %h",
					last_flag, want.is_last, want.code));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_mode = MODE_U8TO32;
			partial_cp = '0;
			units_left = 2'd0;
			expected_units.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				dir_mode = cfg_data[2:0];
				partial_cp = '0;
				units_left = 2'd0;
			end
			if (s_tvalid && s_tready) predict_source(s_tdata);
			if (m_tvalid && m_tready) check_target(m_tdata, m_tlast);
			if (run_done && expected_units.size() != 0) begin
				report_mismatch($sformatf("%0d target units never arrived",
					expected_units.size()));
			end
		end
		pending = expected_units.size();
	end

endmodule

[test/tb_unicode_stream_transcoder_unit.sv]
// Testbench top for unicode_stream_transcoder_unit: drives mode writes and source
// units, throttles the target side, and gives the verdict. Needs ustc_pkg, the RTL
// and ustc_stream_checker, which does all prediction and comparison.
module tb_unicode_stream_transcoder_unit;
	import ustc_pkg::*;

	// unused direction code: the block swallows every unit
	localparam logic [2:0] MODE_SPARE = 3'd7;
	localparam int MAX_IDLE     = 13;
	localparam int HOLD_CYCLES  = 120; // long sink hold-off, fills the job queue
	localparam int SETTLE_TICKS = 8;   // covers decode plus queue/back-end latency
	localparam int DRAIN_TICKS  = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data = '0;   // [2:0] direction_mode
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [SRC_W-1:0]       s_tdata = '0;    // [31:0] source_unit
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [20:0] target_unit, [23:21] zero
	logic                   m_tlast;         // last_unit
	logic                   run_done = 1'b0;

	int chk_errors;
	int pending;
	int units_checked;

	// stimulus bookkeeping
	int units_sent = 0;
	int modes_written = 0;
	int hold_requests = 0;
	int holds_done = 0;
	bit tx_eager = 1'b0; // source side runs without gaps
	bit rx_eager = 1'b0; // sink side runs without stalls

	always #5 clk = ~clk;

	unicode_stream_transcoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	ustc_stream_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.run_done      (run_done),
		.errors        (chk_errors),
		.pending       (pending),
		.units_checked (units_checked)
	);

	// Sets random bits above the used width on about one unit in five; the
	// block must ignore them in the 8- and 16-bit source modes.
	function automatic logic [31:0] dress(input logic [31:0] v, input int unsigned keep_bits);
		logic [31:0] keep_mask;
		keep_mask = (32'h1 << keep_bits) - 32'h1;
		if ($urandom_range(0, 4) == 0) return v | ($urandom() & ~keep_mask);
		return v;
	endfunction

	// One source transaction. valid stays high straight into the next unit
	// when there is no gap, so it is never dropped and raised in one step.
	task automatic send_unit(input logic [31:0] u);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= u;
		do @(posedge clk); while (!s_tready);
		units_sent++;
	endtask

	// Drop valid and wait until every expected unit is out, plus a few
	// cycles for characters that make no output.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Upper cfg_data bits are junk on purpose; only [2:0] selects the mode.
	task automatic write_mode(input logic [2:0] m);
		logic [7:0] junk;
		settle();
		junk = 8'($urandom_range(0, 255));
		cfg_valid <= 1'b1;
		cfg_data <= {junk[CFG_W-4:0], m};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		modes_written++;
	endtask

	// Mostly well-formed UTF-8 with random payload; some stray bytes and
	// non-continuation trail bytes mixed in.
	task automatic send_u8_char();
		int         len;
		int         k;
		logic [7:0] lead;
		if ($urandom_range(0, 6) == 0) begin
			send_unit(dress($urandom_range(0, 255), 8));
			return;
		end
		len = $urandom_range(1, 4);
		case (len)
			1:       lead = 8'($urandom_range(8'h00, 8'h7F));
			2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
			3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
			default: lead = 8'($urandom_range(8'hF0, 8'hF7));
		endcase
		send_unit(dress({24'b0, lead}, 8));
		for (k = 1; k < len; k++) begin
			send_unit(dress(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
				: $urandom_range(8'h80, 8'hBF), 8));
		end
	endtask

	// BMP units and surrogate pairs, with a tenth raw noise (lone trails,
	// leads followed by anything).
	task automatic send_u16_char();
		int          pick;
		logic [15:0] bmp;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			bmp = 16'($urandom_range(0, 16'hFFFF));
			if (bmp >= 16'hD800 && bmp <= 16'hDFFF) bmp = bmp ^ 16'h4000;
			send_unit(dress({16'b0, bmp}, 16));
		end else if (pick < 9) begin
			send_unit(dress($urandom_range(16'hD800, 16'hDBFF), 16));
			send_unit(dress($urandom_range(16'hDC00, 16'hDFFF), 16));
		end else begin
			send_unit(dress($urandom_range(0, 16'hFFFF), 16));
		end
	endtask

	// Code points spread over every encoded length, plus out-of-range values.
	task automatic send_u32_point();
		logic [31:0] cp;
		case ($urandom_range(0, 5))
			0:       cp = $urandom_range(32'h0, 32'h7F);
			1:       cp = $urandom_range(32'h80, 32'h7FF);
			2:       cp = $urandom_range(32'h800, 32'hFFFF);
			3, 4:    cp = $urandom_range(32'h10000, 32'h10FFFF);
			default: cp = $urandom_range(32'h110000, 32'hFFFFFFFF);
		endcase
		send_unit(cp);
	endtask

	// One random stretch in a single direction. Idling is redrawn per phase
	// so some phases run back to back on one or both sides.
	task automatic random_phase(input logic [2:0] m, input int count);
		int start;
		write_mode(m);
		tx_eager = ($urandom_range(0, 3) == 0);
		rx_eager = ($urandom_range(0, 3) == 0);
		start = units_sent;
		while (units_sent - start < count) begin
			case (m)
				MODE_U8TO32, MODE_U8TO16:  send_u8_char();
				MODE_U16TO32, MODE_U16TO8: send_u16_char();
				MODE_U32TO8, MODE_U32TO16: send_u32_point();
				default:                   send_unit($urandom());
			endcase
		end
	endtask

	// Sink: a fresh stall per target unit, or a long hold when the stimulus
	// asks for one. The hold is counted here, not by the source side.
	initial begin : target_sink
		int stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (holds_done != hold_requests) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				stall = rx_eager ? 0 : $urandom_range(0, MAX_IDLE);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Hard stop well past the slowest legal run.
	initial begin : watchdog
		#5_000_000;
		$display("tb_unicode_stream_transcoder_unit: errors");
		$finish;
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset mode is 8-to-32: ASCII extremes, a 2-byte lead with a bogus
		// trail (taken anyway), the largest 4-byte value, invalid leads, and a
		// 3-byte lead left open for the next mode write to abandon
		send_unit(32'h00);
		send_unit(32'h7F);
		send_unit(32'hC2);
		send_unit(32'h41);
		send_unit(32'hF7);
		send_unit(32'hBF);
		send_unit(32'hBF);
		send_unit(32'hBF);
		send_unit(32'h80);
		send_unit(32'hFF);
		send_unit(32'hE2);

		// 8-to-16: euro sign, then an emoji that needs a surrogate pair
		write_mode(MODE_U8TO16);
		send_unit(32'hE2);
		send_unit(32'h82);
		send_unit(32'hAC);
		send_unit(32'hF0);
		send_unit(32'h9F);
		send_unit(32'h98);
		send_unit(32'h80);

		// 16-to-32: a proper pair, a lone trail, a lead with a non-trail
		// partner, and the top BMP unit
		write_mode(MODE_U16TO32);
		send_unit(32'hD83D);
		send_unit(32'hDE00);
		send_unit(32'hDC00);
		send_unit(32'hD800);
		send_unit(32'h0041);
		send_unit(32'hFFFF);

		// 16-to-8: highest code point via a pair
		write_mode(MODE_U16TO8);
		send_unit(32'hDBFF);
		send_unit(32'hDFFF);

		// 32-to-8: last valid point, first invalid, all ones
		write_mode(MODE_U32TO8);
		send_unit(32'h0010FFFF);
		send_unit(32'h00110000);
		send_unit(32'hFFFFFFFF);

		// 32-to-16: a surrogate value passes straight through, first supplementary
		write_mode(MODE_U32TO16);
		send_unit(32'h0000DFFF);
		send_unit(32'h00010000);

		// --- random phases over all directions, the spare code included ---
		random_phase(MODE_U8TO32, 40);
		random_phase(MODE_U32TO8, 40);
		random_phase(MODE_U16TO32, 40);
		random_phase(MODE_U32TO16, 40);
		random_phase(MODE_SPARE, 8);
		random_phase(MODE_U8TO16, 40);
		random_phase(MODE_U16TO8, 40);
		random_phase(MODE_U8TO16, 40);
		random_phase(MODE_U16TO8, 40);

		// --- back-pressure: sink holds off while 4-byte characters keep
		// coming with no gaps, so the job queue fills and s_tready drops ---
		write_mode(MODE_U32TO8);
		tx_eager = 1'b1;
		hold_requests++;
		repeat (16) send_unit($urandom_range(32'h10000, 32'h10FFFF));
		tx_eager = 1'b0;

		// --- drain and verdict ---
		settle();
		repeat (DRAIN_TICKS) @(posedge clk);
		run_done <= 1'b1;
		@(posedge clk);
		run_done <= 1'b0;
		@(posedge clk);

		$display("run covered %0d source units over %0d direction writes (modes 0-5 and 7)",
			units_sent, modes_written);
		$display("%0d target units compared, %0d long sink hold-off(s)",
			units_checked, holds_done);
		if (chk_errors == 0) begin
			$display("tb_unicode_stream_transcoder_unit: clean");
		end else begin
			$display("tb_unicode_stream_transcoder_unit: errors");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/ustc_pkg.sv
rtl/core/ustc_front.sv
rtl/core/ustc_queue.sv
rtl/core/ustc_back.sv
rtl/core/unicode_stream_transcoder_unit.sv
test/ustc_stream_checker.sv
test/tb_unicode_stream_transcoder_unit.sv
